// File: design/osre_pkg.sv
// ----------------------------------------------------------------------------
// osre_pkg
// Shared types and constants of the occluded span run emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package osre_pkg;

  localparam int WIN_SLOTS  = 16;
  localparam int WIN_IDX_W  = $clog2(WIN_SLOTS);
  localparam int SLOT_W     = 4;
  localparam int COORD_W    = 16;
  localparam int SUM_W      = COORD_W + 1;
  localparam int PAINT_W    = 32;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 88;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HSPAN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_VSPAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;

  localparam logic [COORD_W-1:0] SCREEN_W_RST = 16'd1024;
  localparam logic [COORD_W-1:0] SCREEN_H_RST = 16'd768;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic                active;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  rect_width;
    logic [COORD_W-1:0]  rect_height;
    logic [COORD_W-1:0]  span_len;
    logic [PAINT_W-1:0]  paint;
  } in_item_t;

  // window table write
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic               active;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } win_wr_t;

  // one pixel coverage query
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               vert;
    logic [COORD_W-1:0] fixed;
    logic [SUM_W-1:0]   pos;
  } cov_qry_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } seq_state_t;

endpackage

`default_nettype wire

// File: design/osre_win_table.sv
// ----------------------------------------------------------------------------
// osre_win_table
// Window slot table and the pixel coverage tester run against all higher slots.
// ----------------------------------------------------------------------------
`default_nettype none

module osre_win_table (
  input  wire                   clk,
  input  wire                   rst_n,
  input  osre_pkg::win_wr_t     wr,
  input  osre_pkg::cov_qry_t    qry,
  output logic                  covered
);
  import osre_pkg::*;

  logic [COORD_W-1:0] x_r  [WIN_SLOTS];
  logic [COORD_W-1:0] y_r  [WIN_SLOTS];
  logic [SUM_W-1:0]   xe_r [WIN_SLOTS];
  logic [SUM_W-1:0]   ye_r [WIN_SLOTS];
  logic [WIN_SLOTS-1:0] live_r;

  logic [WIN_SLOTS-1:0] hit;
  logic                 wr_ok;

  assign wr_ok = wr.en && (int'(wr.slot) < WIN_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (wr_ok) begin
      // empty or inactive windows hide nothing
      live_r[wr.slot[WIN_IDX_W-1:0]] <= wr.active && (wr.w != '0) && (wr.h != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      x_r[wr.slot[WIN_IDX_W-1:0]]  <= wr.x;
      y_r[wr.slot[WIN_IDX_W-1:0]]  <= wr.y;
      xe_r[wr.slot[WIN_IDX_W-1:0]] <= {1'b0, wr.x} + {1'b0, wr.w};
      ye_r[wr.slot[WIN_IDX_W-1:0]] <= {1'b0, wr.y} + {1'b0, wr.h};
    end
  end

  always_comb begin
    logic [SUM_W-1:0] fx;
    logic             in_x;
    logic             in_y;
    fx = {1'b0, qry.fixed};
    for (int j = 0; j < WIN_SLOTS; j++) begin
      if (qry.vert) begin
        in_x = (fx >= {1'b0, x_r[j]}) && (fx < xe_r[j]);
        in_y = (qry.pos >= {1'b0, y_r[j]}) && (qry.pos < ye_r[j]);
      end else begin
        in_x = (qry.pos >= {1'b0, x_r[j]}) && (qry.pos < xe_r[j]);
        in_y = (fx >= {1'b0, y_r[j]}) && (fx < ye_r[j]);
      end
      hit[j] = live_r[j] && (j > int'(qry.slot)) && in_x && in_y;
    end
  end

  assign covered = |hit;

endmodule

`default_nettype wire

// File: design/osre_seq.sv
// ----------------------------------------------------------------------------
// osre_seq
// Span sequencer: walks a span one pixel a cycle, unless the output stalls, and collects visible runs.
// ----------------------------------------------------------------------------
`default_nettype none

module osre_seq (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  osre_pkg::in_item_t         item,
  input  wire [osre_pkg::COORD_W-1:0] screen_w,
  input  wire [osre_pkg::COORD_W-1:0] screen_h,
  output osre_pkg::win_wr_t          wr,
  output osre_pkg::cov_qry_t         qry,
  input  wire                        covered,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [osre_pkg::SUM_W-1:0]   out_x,
  output logic [osre_pkg::SUM_W-1:0]   out_y,
  output logic [osre_pkg::COORD_W-1:0] out_len,
  output logic                         out_vert,
  output logic [osre_pkg::PAINT_W-1:0] out_paint,
  output logic                         out_last
);
  import osre_pkg::*;

  seq_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]    cur_r, cur_nxt;
  logic [SUM_W-1:0]    end_r, end_nxt;
  logic                vert_r, vert_nxt;
  logic [COORD_W-1:0]  fixed_r, fixed_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [PAINT_W-1:0]  paint_r, paint_nxt;
  logic                run_v_r, run_v_nxt;
  logic                run_open_r, run_open_nxt;
  logic [SUM_W-1:0]    run_start_r, run_start_nxt;
  logic [COORD_W-1:0]  run_len_r, run_len_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    out_x_r, out_y_r;
  logic [COORD_W-1:0]  out_len_r;
  logic                out_vert_r, out_last_r;
  logic [PAINT_W-1:0]  out_paint_r;

  logic acc, span_ok, at_end, free, emit, emit_last;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign free     = !out_valid_r || out_ready;
  assign at_end   = (cur_r == end_r);

  assign span_ok = (item.span_len != '0) &&
                   (((item.action == ACT_HSPAN) && (item.pos_y < screen_h)) ||
                    ((item.action == ACT_VSPAN) && (item.pos_x < screen_w)));

  always_comb begin
    wr.en     = acc && (item.action == ACT_WRITE);
    wr.slot   = item.slot;
    wr.active = item.active;
    wr.x      = item.pos_x;
    wr.y      = item.pos_y;
    wr.w      = item.rect_width;
    wr.h      = item.rect_height;
  end

  always_comb begin
    qry.slot  = slot_r;
    qry.vert  = vert_r;
    qry.fixed = fixed_r;
    qry.pos   = cur_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    vert_nxt      = vert_r;
    fixed_nxt     = fixed_r;
    slot_nxt      = slot_r;
    paint_nxt     = paint_r;
    run_v_nxt     = run_v_r;
    run_open_nxt  = run_open_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    emit          = 1'b0;
    emit_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && span_ok) begin
          vert_nxt     = (item.action == ACT_VSPAN);
          fixed_nxt    = (item.action == ACT_VSPAN) ? item.pos_x : item.pos_y;
          cur_nxt      = {1'b0, (item.action == ACT_VSPAN) ? item.pos_y : item.pos_x};
          end_nxt      = {1'b0, (item.action == ACT_VSPAN) ? item.pos_y : item.pos_x} +
                         {1'b0, item.span_len};
          slot_nxt     = item.slot;
          paint_nxt    = item.paint;
          run_v_nxt    = 1'b0;
          run_open_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          if (!run_v_r) begin
            state_nxt = ST_IDLE;
          end else if (free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            run_v_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else if (covered) begin
          run_open_nxt = 1'b0;
          cur_nxt      = cur_r + SUM_W'(1);
        end else if (run_v_r && run_open_r) begin
          run_len_nxt = run_len_r + COORD_W'(1);
          cur_nxt     = cur_r + SUM_W'(1);
        end else if (!run_v_r || free) begin
          // a closed run goes out once another visible pixel follows, or at the span end
          emit          = run_v_r;
          run_v_nxt     = 1'b1;
          run_open_nxt  = 1'b1;
          run_start_nxt = cur_r;
          run_len_nxt   = COORD_W'(1);
          cur_nxt       = cur_r + SUM_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_v_r     <= 1'b0;
      run_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_v_r     <= run_v_nxt;
      run_open_r  <= run_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    end_r       <= end_nxt;
    vert_r      <= vert_nxt;
    fixed_r     <= fixed_nxt;
    slot_r      <= slot_nxt;
    paint_r     <= paint_nxt;
    run_start_r <= run_start_nxt;
    run_len_r   <= run_len_nxt;
    if (emit) begin
      out_x_r     <= vert_r ? {1'b0, fixed_r} : run_start_r;
      out_y_r     <= vert_r ? run_start_r : {1'b0, fixed_r};
      out_len_r   <= run_len_r;
      out_vert_r  <= vert_r;
      out_paint_r <= paint_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_len   = out_len_r;
  assign out_vert  = out_vert_r;
  assign out_paint = out_paint_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: design/occluded_span_run_emitter.sv
// ----------------------------------------------------------------------------
// occluded_span_run_emitter
// Clips horizontal and vertical spans against a stack of window rectangles.
// ----------------------------------------------------------------------------
// A write word loads one window slot. A span word walks its pixels one per
// cycle unless the result side stalls, each pixel tested at once against every
// active window in a higher slot, and holds the input until its walk ends.
// Visible runs come out in order along the span, the final one with tlast. A
// dropped or empty span produces nothing and leaves the input ready; a fully
// hidden span produces nothing but still walks all of its pixels. The screen
// size registers are written through the cfg port while idle: the user must
// keep to this, as the block itself does not enforce it.
`default_nettype none

module occluded_span_run_emitter (
  input  wire                                clk,
  input  wire                                rst_n,
  // action
  input  wire [osre_pkg::ACTION_W-1:0]       in_tuser,
  // slot, active, pos_x, pos_y, rect_width, rect_height, span_len, paint, pad
  input  wire [osre_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // run_x, run_y, run_len, run_paint, pad
  output logic [osre_pkg::OUT_DATA_W-1:0]    out_tdata,
  // vertical
  output logic                               out_tuser,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [osre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [osre_pkg::COORD_W-1:0]        cfg_data
);
  import osre_pkg::*;

  in_item_t           item;
  win_wr_t            wr;
  cov_qry_t           qry;
  logic               covered;
  logic [COORD_W-1:0] screen_w_r, screen_h_r;
  logic [SUM_W-1:0]   run_x, run_y;
  logic [COORD_W-1:0] run_len;
  logic [PAINT_W-1:0] run_paint;

  always_comb begin
    item.action      = in_tuser;
    item.slot        = in_tdata[3:0];
    item.active      = in_tdata[4];
    item.pos_x       = in_tdata[20:5];
    item.pos_y       = in_tdata[36:21];
    item.rect_width  = in_tdata[52:37];
    item.rect_height = in_tdata[68:53];
    item.span_len    = in_tdata[84:69];
    item.paint       = in_tdata[116:85];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_W: screen_w_r <= cfg_data;
        CFG_SCREEN_H: screen_h_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  osre_win_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .qry     (qry),
    .covered (covered)
  );

  osre_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .screen_w  (screen_w_r),
    .screen_h  (screen_h_r),
    .wr        (wr),
    .qry       (qry),
    .covered   (covered),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (run_x),
    .out_y     (run_y),
    .out_len   (run_len),
    .out_vert  (out_tuser),
    .out_paint (run_paint),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, run_paint, run_len, run_y, run_x};

endmodule

`default_nettype wire
